@@ src/bqhr_pkg.sv @@
package bqhr_pkg;

   // line store geometry
   localparam int MAX_LINE_WIDTH   = 2048;
   localparam int COL_W            = $clog2(MAX_LINE_WIDTH);
   localparam int BANK_DEPTH       = MAX_LINE_WIDTH / 2;
   localparam int BANK_AW          = COL_W - 1;

   // frame geometry
   localparam int MAX_FRAME_HEIGHT = 4096;
   localparam int ROW_W            = 12;

   // register and payload widths
   localparam int PIX_W            = 8;
   localparam int LW_W             = 12;
   localparam int FH_W             = 13;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 13;

   localparam logic [LW_W-1:0] RESET_LINE_WIDTH   = 12'd1360;
   localparam logic [FH_W-1:0] RESET_FRAME_HEIGHT = 13'd1024;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LINE_WIDTH   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

   // what the raster position says about the pixel at the input
   typedef struct packed {
      logic               emit;     // lower-right of a complete quad
      logic               last;     // final quad of the frame
      logic               hold;     // lower-left of a complete quad
      logic               wr_even;  // even row, even column
      logic               wr_odd;   // even row, odd column
      logic [BANK_AW-1:0] addr;     // column pair
   } step_type;

endpackage

@@ src/bqhr_req_if.sv @@
interface bqhr_req_if;
   import bqhr_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] raw_pixel;

   modport source (output valid, output raw_pixel, input ready);
   modport sink   (input valid, input raw_pixel, output ready);
endinterface

@@ src/bqhr_rsp_if.sv @@
interface bqhr_rsp_if;
   import bqhr_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;
   logic             last_of_frame;

   modport source (output valid, output red, output green, output blue,
                   output last_of_frame, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input last_of_frame, output ready);
endinterface

@@ src/bqhr_line_buf.sv @@
module bqhr_line_buf (
   input  logic                         clock,
   input  logic                         accept,
   input  bqhr_pkg::step_type           step,
   input  logic [bqhr_pkg::PIX_W-1:0]   wr_data,
   output logic [bqhr_pkg::PIX_W-1:0]   rd_even_ff,
   output logic [bqhr_pkg::PIX_W-1:0]   rd_odd_ff
);
   import bqhr_pkg::*;

   // even-row pixels split by column parity, one pair per address
   logic [PIX_W-1:0] even_mem [BANK_DEPTH];
   logic [PIX_W-1:0] odd_mem  [BANK_DEPTH];

   // write during even rows
   always_ff @(posedge clock) begin
      if (accept && step.wr_even) begin
         even_mem[step.addr] <= wr_data;
      end
      if (accept && step.wr_odd) begin
         odd_mem[step.addr] <= wr_data;
      end
   end

   // fetch the upper pair on every odd-row beat; the lower-right pixel
   // uses the pair fetched by its left neighbor, even if the geometry moved
   always_ff @(posedge clock) begin
      if (accept && !step.wr_even && !step.wr_odd) begin
         rd_even_ff <= even_mem[step.addr];
         rd_odd_ff  <= odd_mem[step.addr];
      end
   end

endmodule

@@ src/bqhr_raster.sv @@
module bqhr_raster (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bqhr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bqhr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              accept,
   output bqhr_pkg::step_type                step
);
   import bqhr_pkg::*;

   logic [LW_W-1:0]  line_width_ff, line_width_in;
   logic [FH_W-1:0]  frame_height_ff, frame_height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [COL_W:0]   eff_w, wq, col_ext, col_inc;
   logic [FH_W-1:0]  eff_h, hq, row_ext, row_inc;
   logic             odd_row, in_quad, col_wrap, row_wrap;

   // configuration registers
   always_comb begin
      line_width_in   = line_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_LINE_WIDTH:   line_width_in   = csr_wdata[LW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_in = csr_wdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped frame geometry and quad-aligned bounds
   always_comb begin
      if (line_width_ff < LW_W'(2)) begin
         eff_w = (COL_W+1)'(2);
      end else if (32'(line_width_ff) > MAX_LINE_WIDTH) begin
         eff_w = (COL_W+1)'(MAX_LINE_WIDTH);
      end else begin
         eff_w = (COL_W+1)'(line_width_ff);
      end
      if (frame_height_ff < FH_W'(2)) begin
         eff_h = FH_W'(2);
      end else if (32'(frame_height_ff) > MAX_FRAME_HEIGHT) begin
         eff_h = FH_W'(MAX_FRAME_HEIGHT);
      end else begin
         eff_h = frame_height_ff;
      end
      wq = {eff_w[COL_W:1], 1'b0};
      hq = {eff_h[FH_W-1:1], 1'b0};
   end

   // decode the current position
   always_comb begin
      col_ext  = {1'b0, col_ff};
      row_ext  = FH_W'(row_ff);
      col_inc  = col_ext + (COL_W+1)'(1);
      row_inc  = row_ext + FH_W'(1);
      col_wrap = col_inc >= eff_w;
      row_wrap = row_inc >= eff_h;
      odd_row  = row_ff[0];
      in_quad  = odd_row && (row_ext < hq) && (col_ext < wq);

      step.emit    = in_quad && col_ff[0];
      step.hold    = in_quad && !col_ff[0];
      step.last    = (row_ext == hq - FH_W'(1)) && (col_ext == wq - (COL_W+1)'(1));
      step.wr_even = !odd_row && !col_ff[0];
      step.wr_odd  = !odd_row && col_ff[0];
      step.addr    = col_ff[COL_W-1:1];
   end

   // raster advance on each input beat
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= RESET_LINE_WIDTH;
         frame_height_ff <= RESET_FRAME_HEIGHT;
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         line_width_ff   <= line_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
      end
   end

endmodule

@@ src/bayer_quad_to_half_rgb_top.sv @@
// A result beat is valid in the cycle after its lower-right pixel is accepted.
// Throughput: one pixel per cycle; pixels stall only while a result beat waits
//   at the output and the pixel at the input would make another one.
// Reset clears the raster counters, held green, output valid and loads the
//   register defaults (width 1360, height 1024); the line store is not cleared.
module bayer_quad_to_half_rgb_top (
   input  logic                              clock,
   input  logic                              reset,
   bqhr_req_if.sink                          req_bus,
   bqhr_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [bqhr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bqhr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bqhr_pkg::*;

   step_type         step;
   logic             accept;
   logic [PIX_W-1:0] rd_even_ff, rd_odd_ff;
   logic [PIX_W:0]   green_sum;

   logic [PIX_W-1:0] held_green_ff, held_green_in;
   logic             out_valid_ff, out_valid_in;
   logic [PIX_W-1:0] red_ff, green_ff, blue_ff;
   logic             last_ff;

   // stall only when this pixel makes a beat and the output is full
   assign req_bus.ready = !step.emit || !out_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   bqhr_raster u_raster (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .step      (step)
   );

   bqhr_line_buf u_line_buf (
      .clock      (clock),
      .accept     (accept),
      .step       (step),
      .wr_data    (req_bus.raw_pixel),
      .rd_even_ff (rd_even_ff),
      .rd_odd_ff  (rd_odd_ff)
   );

   // lower-left green of the current quad
   assign held_green_in = (accept && step.hold) ? req_bus.raw_pixel : held_green_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_green_ff <= '0;
      end else begin
         held_green_ff <= held_green_in;
      end
   end

   // output register
   assign green_sum    = {1'b0, rd_odd_ff} + {1'b0, held_green_ff};
   assign out_valid_in = (accept && step.emit) || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step.emit) begin
         red_ff   <= rd_even_ff;
         green_ff <= green_sum[PIX_W:1];
         blue_ff  <= req_bus.raw_pixel;
         last_ff  <= step.last;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.red           = red_ff;
   assign rsp_bus.green         = green_ff;
   assign rsp_bus.blue          = blue_ff;
   assign rsp_bus.last_of_frame = last_ff;

endmodule

@@ src/bqhr_checker.sv @@
module bqhr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [bqhr_pkg::PIX_W-1:0] rsp_red,
   input logic [bqhr_pkg::PIX_W-1:0] rsp_green,
   input logic [bqhr_pkg::PIX_W-1:0] rsp_blue,
   input logic                      rsp_last
);
   import bqhr_pkg::*;

   // a stalled result beat stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // and keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_red, rsp_green, rsp_blue, rsp_last}))
      else $error("result payload changed while stalled");

   // a new result beat only follows an accepted pixel
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result beat without an input beat");

   // input stalls only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled with the output free");

endmodule

bind bayer_quad_to_half_rgb_top bqhr_checker u_bqhr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_red   (rsp_bus.red),
   .rsp_green (rsp_bus.green),
   .rsp_blue  (rsp_bus.blue),
   .rsp_last  (rsp_bus.last_of_frame)
);
